// ===== rtl/phdx_pkg.sv =====
package phdx_pkg;

    localparam int MAX_DATAGRAM_DEF = 2048;
    localparam int HEADER_BYTES     = 24;
    localparam int CAP_W            = 12;
    localparam logic [CAP_W-1:0] CAP_RESET = 12'd1500;

    localparam int POS_TYPE     = 5;
    localparam int POS_STREAM   = 8;
    localparam int POS_SEQUENCE = 12;
    localparam int POS_LENGTH   = 20;

    localparam int S_DATA_W  = 8;
    localparam int M_DATA_W  = 152;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 12;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_TOO_SHORT = 2'd1,
        STATUS_MISMATCH  = 2'd2,
        STATUS_OVER_CAP  = 2'd3
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_XOR_KEY    = 2'd0,
        CFG_DECRYPT_EN = 2'd1,
        CFG_CAPACITY   = 2'd2
    } cfg_reg_t;

    typedef enum logic {
        KIND_PAYLOAD = 1'b0,
        KIND_STATUS  = 1'b1
    } kind_t;

    typedef struct packed {
        logic [7:0]       xor_key;
        logic             decrypt_enable;
        logic [CAP_W-1:0] payload_capacity;
    } cfg_t;

    typedef struct packed {
        kind_t               kind;
        logic                last;
        logic [M_DATA_W-1:0] data;
    } result_t;

    typedef struct packed {
        logic    pay_valid;
        logic    stat_valid;
        result_t pay;
        result_t stat;
    } res_pair_t;

    function automatic logic [M_DATA_W-1:0] pack_status(
        input status_t     st,
        input logic [7:0]  packet_type,
        input logic [31:0] stream_number,
        input logic [63:0] sequence_number,
        input logic [31:0] payload_length
    );
        return {6'd0, payload_length, sequence_number, stream_number,
                packet_type, st, 8'd0};
    endfunction

endpackage

// ===== rtl/phdx_parse.sv =====
module phdx_parse #(
    parameter int MAX_DATAGRAM = phdx_pkg::MAX_DATAGRAM_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  phdx_pkg::cfg_t       cfg,
    input  logic                 take,
    input  logic [7:0]           data_byte,
    input  logic                 end_of_datagram,
    output phdx_pkg::res_pair_t  res
);
    import phdx_pkg::*;

    localparam int CNT_W = $clog2(MAX_DATAGRAM + 1);

    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [7:0]       type_reg, type_next;
    logic [31:0]      stream_reg, stream_next;
    logic [63:0]      seq_reg, seq_next;
    logic [31:0]      len_reg, len_next;
    logic             below_max;
    logic             in_header;
    logic [7:0]       pay_byte;
    status_t          st;

    assign below_max = cnt_reg < CNT_W'(MAX_DATAGRAM);
    assign in_header = cnt_reg < CNT_W'(HEADER_BYTES);

    always_comb begin
        cnt_next    = cnt_reg;
        type_next   = type_reg;
        stream_next = stream_reg;
        seq_next    = seq_reg;
        len_next    = len_reg;
        if (below_max) begin
            cnt_next = cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_W'(POS_TYPE)) begin
                type_next = data_byte;
            end else if (cnt_reg >= CNT_W'(POS_STREAM) && cnt_reg < CNT_W'(POS_SEQUENCE)) begin
                stream_next = {stream_reg[23:0], data_byte};
            end else if (cnt_reg >= CNT_W'(POS_SEQUENCE) && cnt_reg < CNT_W'(POS_LENGTH)) begin
                seq_next = {seq_reg[55:0], data_byte};
            end else if (cnt_reg >= CNT_W'(POS_LENGTH) && in_header) begin
                len_next = {len_reg[23:0], data_byte};
            end
        end
    end

    always_comb begin
        if (cnt_next < CNT_W'(HEADER_BYTES)) begin
            st = STATUS_TOO_SHORT;
        end else if ({1'b0, len_next} + 33'(HEADER_BYTES) != 33'(cnt_next)) begin
            st = STATUS_MISMATCH;
        end else if (len_next > 32'(cfg.payload_capacity)) begin
            st = STATUS_OVER_CAP;
        end else begin
            st = STATUS_OK;
        end
    end

    assign pay_byte = cfg.decrypt_enable ? (data_byte ^ cfg.xor_key) : data_byte;

    always_comb begin
        res.pay_valid  = take && below_max && !in_header;
        res.stat_valid = take && end_of_datagram;
        res.pay.kind   = KIND_PAYLOAD;
        res.pay.last   = 1'b0;
        res.pay.data   = {{(M_DATA_W-8){1'b0}}, pay_byte};
        res.stat.kind  = KIND_STATUS;
        res.stat.last  = 1'b1;
        res.stat.data  = pack_status(st, type_next, stream_next, seq_next, len_next);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg    <= '0;
            type_reg   <= '0;
            stream_reg <= '0;
            seq_reg    <= '0;
            len_reg    <= '0;
        end else if (take) begin
            if (end_of_datagram) begin
                cnt_reg    <= '0;
                type_reg   <= '0;
                stream_reg <= '0;
                seq_reg    <= '0;
                len_reg    <= '0;
            end else begin
                cnt_reg    <= cnt_next;
                type_reg   <= type_next;
                stream_reg <= stream_next;
                seq_reg    <= seq_next;
                len_reg    <= len_next;
            end
        end
    end

endmodule

// ===== rtl/packet_header_deframer_xor.sv =====
// Datagram deframer with optional XOR payload decryption.
// Input stream (s_*): one datagram byte per beat in s_tdata[7:0]; s_tlast marks
// the final byte. The first 24 bytes are the header; later bytes are payload.
// Output stream (m_*): m_tuser 0 is a payload beat (byte in m_tdata[7:0]);
// m_tuser 1 with m_tlast is the status beat closing the datagram, carrying the
// outcome and the decoded type, stream id, sequence number and length fields.
// Payload beats must be dropped downstream unless the status is ok.
// Bytes past MAX_DATAGRAM are dropped without a payload beat.
// Configuration (cfg_*): index 0 key, 1 decrypt enable, 2 payload capacity;
// always ready, write only while the stream is idle.
// Each result enters a four-entry result queue as its input beat is taken.
// Throughput: one byte per cycle while s_tready is high; a final beat that
// also carries payload makes two output beats, drained one per cycle while
// m_tready is high. s_tready drops while the queue has fewer than two free
// entries, so a stalled receiver backs up the input with no result lost.
// Reset (synchronous, aresetn low): queue empty, parser at the start of a
// datagram, key 0, decrypt off, capacity 1500.
module packet_header_deframer_xor #(
    parameter int MAX_DATAGRAM = phdx_pkg::MAX_DATAGRAM_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [phdx_pkg::S_DATA_W-1:0]     s_tdata,   // data_byte
    input  logic                              s_tlast,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // payload_byte, status, packet_type, stream_number, sequence_number,
    // payload_length, zero pad
    output logic [phdx_pkg::M_DATA_W-1:0]     m_tdata,
    output logic                              m_tuser,   // kind
    output logic                              m_tlast,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [phdx_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [phdx_pkg::CFG_DAT_W-1:0]    cfg_data
);
    import phdx_pkg::*;

    cfg_t      cfg_reg;
    res_pair_t res;
    logic      s_take;
    logic      m_take;
    logic [1:0] n_push;
    result_t   first_res;

    result_t                fifo_mem_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [FIFO_CNT_W-1:0]  fifo_cnt_reg, fifo_cnt_next;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.xor_key          <= '0;
            cfg_reg.decrypt_enable   <= 1'b0;
            cfg_reg.payload_capacity <= CAP_RESET;
        end else if (cfg_valid) begin
            case (cfg_reg_t'(cfg_index))
                CFG_XOR_KEY:    cfg_reg.xor_key          <= cfg_data[7:0];
                CFG_DECRYPT_EN: cfg_reg.decrypt_enable   <= cfg_data[0];
                CFG_CAPACITY:   cfg_reg.payload_capacity <= cfg_data[CAP_W-1:0];
                default: ;
            endcase
        end
    end

    assign s_tready = fifo_cnt_reg <= FIFO_CNT_W'(FIFO_DEPTH - 2);
    assign s_take   = s_tvalid && s_tready;
    assign m_tvalid = fifo_cnt_reg != '0;
    assign m_take   = m_tvalid && m_tready;

    phdx_parse #(
        .MAX_DATAGRAM(MAX_DATAGRAM)
    ) u_parse (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg             (cfg_reg),
        .take            (s_take),
        .data_byte       (s_tdata[7:0]),
        .end_of_datagram (s_tlast),
        .res             (res)
    );

    assign n_push        = {1'b0, res.pay_valid} + {1'b0, res.stat_valid};
    assign first_res     = res.pay_valid ? res.pay : res.stat;
    assign fifo_cnt_next = fifo_cnt_reg + FIFO_CNT_W'(n_push) - FIFO_CNT_W'(m_take);

    always_ff @(posedge aclk) begin
        if (n_push != 2'd0) begin
            fifo_mem_reg[wr_ptr_reg] <= first_res;
        end
        if (n_push == 2'd2) begin
            fifo_mem_reg[wr_ptr_reg + FIFO_PTR_W'(1)] <= res.stat;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg   <= '0;
            rd_ptr_reg   <= '0;
            fifo_cnt_reg <= '0;
        end else begin
            wr_ptr_reg   <= wr_ptr_reg + FIFO_PTR_W'(n_push);
            rd_ptr_reg   <= rd_ptr_reg + FIFO_PTR_W'(m_take);
            fifo_cnt_reg <= fifo_cnt_next;
        end
    end

    assign m_tdata = fifo_mem_reg[rd_ptr_reg].data;
    assign m_tuser = fifo_mem_reg[rd_ptr_reg].kind;
    assign m_tlast = fifo_mem_reg[rd_ptr_reg].last;

    a_end_gives_status: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tlast |=> m_tvalid)
        else $error("end beat did not queue a status beat");

    a_fifo_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fifo_cnt_reg <= FIFO_CNT_W'(FIFO_DEPTH))
        else $error("result queue overflow");

    a_status_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tuser == m_tlast))
        else $error("status beat and tlast disagree");

endmodule

// ===== verif/deframe_checker.sv =====
module deframe_checker #(
    parameter int MAX_BYTES = phdx_pkg::MAX_DATAGRAM_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    input  logic                              s_tready,
    input  logic [phdx_pkg::S_DATA_W-1:0]     s_tdata,
    input  logic                              s_tlast,
    input  logic                              m_tvalid,
    input  logic                              m_tready,
    input  logic [phdx_pkg::M_DATA_W-1:0]     m_tdata,
    input  logic                              m_tuser,
    input  logic                              m_tlast,
    input  logic                              cfg_valid,
    input  logic                              cfg_ready,
    input  logic [phdx_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [phdx_pkg::CFG_DAT_W-1:0]    cfg_data,
    output int                                mismatches,
    output int                                outstanding,
    output int                                input_beats,
    output int                                payload_beats,
    output int                                outcome_ok,
    output int                                outcome_short,
    output int                                outcome_mismatch,
    output int                                outcome_overcap
);
    import phdx_pkg::*;

    localparam int ST_LO     = 8;
    localparam int TYPE_LO   = 10;
    localparam int STREAM_LO = 18;
    localparam int SEQ_LO    = 50;
    localparam int LEN_LO    = 114;
    localparam int PAD_LO    = 146;

    typedef struct packed {
        kind_t       kind;
        logic        last;
        logic [7:0]  pay;
        status_t     st;
        logic [7:0]  ptype;
        logic [31:0] stream;
        logic [63:0] seq;
        logic [31:0] len;
    } deframed_t;

    deframed_t expected_beats[$];

    logic [7:0]       key_q;
    logic             decrypt_q;
    logic [CAP_W-1:0] capacity_q;

    logic [11:0] byte_count;
    logic [7:0]  type_q;
    logic [31:0] stream_q;
    logic [63:0] seq_q;
    logic [31:0] len_q;

    task automatic clear_datagram();
        byte_count = '0;
        type_q     = '0;
        stream_q   = '0;
        seq_q      = '0;
        len_q      = '0;
    endtask

    task automatic predict_datagram_byte(input logic [7:0] b, input logic fin);
        deframed_t r;
        logic [11:0] pos;
        if (byte_count < MAX_BYTES) begin
            pos = byte_count;
            if (pos < HEADER_BYTES) begin
                if (pos == POS_TYPE)
                    type_q = b;
                else if (pos >= POS_STREAM && pos < POS_SEQUENCE)
                    stream_q = {stream_q[23:0], b};
                else if (pos >= POS_SEQUENCE && pos < POS_LENGTH)
                    seq_q = {seq_q[55:0], b};
                else if (pos >= POS_LENGTH)
                    len_q = {len_q[23:0], b};
            end else begin
                r = '0;
                r.kind = KIND_PAYLOAD;
                r.pay = decrypt_q ? (b ^ key_q) : b;
                expected_beats.push_back(r);
            end
            byte_count = pos + 12'd1;
        end
        if (fin) begin
            r = '0;
            r.kind = KIND_STATUS;
            r.last = 1'b1;
            if (byte_count < HEADER_BYTES)
                r.st = STATUS_TOO_SHORT;
            else if ({1'b0, len_q} + 33'(HEADER_BYTES) != 33'(byte_count))
                r.st = STATUS_MISMATCH;
            else if (len_q > 32'(capacity_q))
                r.st = STATUS_OVER_CAP;
            else
                r.st = STATUS_OK;
            r.ptype  = type_q;
            r.stream = stream_q;
            r.seq    = seq_q;
            r.len    = len_q;
            expected_beats.push_back(r);
            clear_datagram();
        end
    endtask

    task automatic compare_beat();
        deframed_t e;
        logic bad;
        if (expected_beats.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected result beat: tuser %0d tlast %0d tdata %h",
                         m_tuser, m_tlast, m_tdata);
            return;
        end
        e = expected_beats.pop_front();
        if (e.kind == KIND_PAYLOAD)
            payload_beats++;
        else
            case (e.st)
                STATUS_OK:        outcome_ok++;
                STATUS_TOO_SHORT: outcome_short++;
                STATUS_MISMATCH:  outcome_mismatch++;
                default:          outcome_overcap++;
            endcase
        bad = (m_tuser !== e.kind) || (m_tlast !== e.last)
            || (m_tdata[7:0] !== e.pay)
            || (m_tdata[ST_LO +: 2] !== e.st)
            || (m_tdata[TYPE_LO +: 8] !== e.ptype)
            || (m_tdata[STREAM_LO +: 32] !== e.stream)
            || (m_tdata[SEQ_LO +: 64] !== e.seq)
            || (m_tdata[LEN_LO +: 32] !== e.len)
            || (m_tdata[M_DATA_W-1:PAD_LO] !== '0);
        if (bad) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("expected: kind %0d last %0d byte %02h status %0d type %02h %s",
                         e.kind, e.last, e.pay, e.st, e.ptype,
                         $sformatf("stream %08h seq %016h len %08h pad 0",
                                   e.stream, e.seq, e.len));
                $display("actual:   kind %0d last %0d byte %02h status %0d type %02h %s",
                         m_tuser, m_tlast, m_tdata[7:0], m_tdata[ST_LO +: 2],
                         m_tdata[TYPE_LO +: 8],
                         $sformatf("stream %08h seq %016h len %08h pad %0h",
                                   m_tdata[STREAM_LO +: 32], m_tdata[SEQ_LO +: 64],
                                   m_tdata[LEN_LO +: 32], m_tdata[M_DATA_W-1:PAD_LO]));
            end
        end
    endtask

    initial begin
        mismatches       = 0;
        outstanding      = 0;
        input_beats      = 0;
        payload_beats    = 0;
        outcome_ok       = 0;
        outcome_short    = 0;
        outcome_mismatch = 0;
        outcome_overcap  = 0;
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            key_q      = '0;
            decrypt_q  = 1'b0;
            capacity_q = CAP_RESET;
            clear_datagram();
            expected_beats.delete();
        end else begin
            if (cfg_valid && cfg_ready)
                case (cfg_index)
                    CFG_XOR_KEY:    key_q = cfg_data[7:0];
                    CFG_DECRYPT_EN: decrypt_q = cfg_data[0];
                    CFG_CAPACITY:   capacity_q = cfg_data[CAP_W-1:0];
                    default: ;
                endcase
            if (s_tvalid && s_tready) begin
                input_beats++;
                predict_datagram_byte(s_tdata, s_tlast);
            end
            if (m_tvalid && m_tready)
                compare_beat();
        end
        outstanding = expected_beats.size();
    end

endmodule

// ===== verif/testbench.sv =====
module testbench;
    import phdx_pkg::*;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic [S_DATA_W-1:0]   s_tdata   = '0;
    logic                  s_tlast   = 1'b0;
    logic                  m_tready  = 1'b1;
    logic                  cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = CFG_XOR_KEY;
    logic [CFG_DAT_W-1:0]  cfg_data  = '0;
    logic                  s_tready;
    logic                  m_tvalid;
    logic [M_DATA_W-1:0]   m_tdata;
    logic                  m_tuser;
    logic                  m_tlast;
    logic                  cfg_ready;

    int mismatches, outstanding, input_beats, payload_beats;
    int outcome_ok, outcome_short, outcome_mismatch, outcome_overcap;

    bit         idle_en = 1'b1;
    int         items_sent = 0;
    logic [7:0] frame_q[$];

    packet_header_deframer_xor uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    deframe_checker checker_i (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_tvalid         (s_tvalid),
        .s_tready         (s_tready),
        .s_tdata          (s_tdata),
        .s_tlast          (s_tlast),
        .m_tvalid         (m_tvalid),
        .m_tready         (m_tready),
        .m_tdata          (m_tdata),
        .m_tuser          (m_tuser),
        .m_tlast          (m_tlast),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .mismatches       (mismatches),
        .outstanding      (outstanding),
        .input_beats      (input_beats),
        .payload_beats    (payload_beats),
        .outcome_ok       (outcome_ok),
        .outcome_short    (outcome_short),
        .outcome_mismatch (outcome_mismatch),
        .outcome_overcap  (outcome_overcap)
    );

    always #1 aclk = ~aclk;

    initial begin
        #2000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        forever begin
            @(negedge aclk);
            if (idle_en && aresetn && $urandom_range(0, 4) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 4)) @(negedge aclk);
                m_tready <= 1'b1;
            end
        end
    end

    task automatic put_beat(input logic [7:0] b, input logic fin);
        if (idle_en && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= fin;
        do @(posedge aclk); while (!s_tready);
        items_sent++;
        @(negedge aclk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DAT_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
    endtask

    task automatic program_regs(input logic [7:0] key, input logic en,
                                input logic [CAP_W-1:0] cap);
        write_reg(CFG_XOR_KEY, CFG_DAT_W'(key));
        write_reg(CFG_DECRYPT_EN, CFG_DAT_W'(en));
        write_reg(CFG_CAPACITY, cap);
        cfg_valid <= 1'b0;
    endtask

    // hold the input until every predicted beat has drained
    task automatic drain();
        s_tvalid <= 1'b0;
        while (outstanding != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic push_be(input logic [63:0] v, input int nbytes);
        for (int i = nbytes - 1; i >= 0; i--)
            frame_q.push_back(v[8*i +: 8]);
    endtask

    task automatic build_header(input logic [31:0] lenf);
        frame_q.delete();
        repeat (8) frame_q.push_back(8'($urandom));
        push_be(64'($urandom), 4);
        push_be({$urandom, $urandom}, 8);
        push_be(64'(lenf), 4);
    endtask

    task automatic add_payload(input int n);
        repeat (n) frame_q.push_back(8'($urandom));
    endtask

    task automatic send_frame();
        foreach (frame_q[i])
            put_beat(frame_q[i], i == frame_q.size() - 1);
    endtask

    task automatic random_frame();
        int pick;
        int plen;
        int n;
        logic [31:0] lenf;
        pick = $urandom_range(0, 99);
        plen = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 300) : $urandom_range(0, 24);
        if (pick < 60) begin
            build_header(plen);
            add_payload(plen);
        end else if (pick < 75) begin
            case ($urandom_range(0, 2))
                0:       lenf = $urandom;
                1:       lenf = plen + 1;
                default: lenf = plen - 1;
            endcase
            build_header(lenf);
            add_payload(plen);
        end else if (pick < 85) begin
            build_header($urandom);
            n = $urandom_range(1, 23);
            while (frame_q.size() > n) void'(frame_q.pop_back());
        end else if (pick < 95) begin
            frame_q.delete();
            add_payload($urandom_range(1, 64));
        end else begin
            build_header($urandom_range(0, 3));
        end
        send_frame();
        if ($urandom_range(0, 39) == 0)
            drain();
    endtask

    initial begin
        logic [7:0]       key;
        logic             en;
        logic [CAP_W-1:0] cap;
        int               phase_start;

        repeat (3) @(negedge aclk);
        aresetn <= 1'b1;

        frame_q.delete();
        frame_q.push_back(8'hFF);
        send_frame();
        frame_q.delete();
        repeat (24) frame_q.push_back(8'hFF);
        send_frame();
        drain();

        for (int p = 0; p < 5; p++) begin
            case (p)
                0: begin key = 8'($urandom_range(1, 254)); en = 1'b1; cap = 12'd1500; end
                1: begin key = 8'hFF; en = 1'b1; cap = 12'd0; end
                2: begin key = 8'h00; en = 1'b1; cap = 12'd2048; end
                3: begin
                    key = 8'($urandom);
                    en  = 1'b0;
                    cap = 12'($urandom_range(0, 300));
                end
                default: begin key = 8'($urandom); en = 1'b1; cap = 12'd1500; end
            endcase
            if (p == 4)
                idle_en = 1'b0;
            program_regs(key, en, cap);
            // truncated datagram: header claims exactly the bytes kept
            if (p == 2) begin
                build_header(MAX_DATAGRAM_DEF - HEADER_BYTES);
                add_payload(MAX_DATAGRAM_DEF - HEADER_BYTES + $urandom_range(1, 6));
                send_frame();
            end
            phase_start = items_sent;
            while (items_sent - phase_start < 320)
                random_frame();
            drain();
        end

        repeat (8) @(negedge aclk);
        $display("Run covered %0d input bytes, %0d payload beats, %0d status beats",
                 input_beats, payload_beats,
                 outcome_ok + outcome_short + outcome_mismatch + outcome_overcap);
        $display("Outcomes: %0d ok, %0d too short, %0d length mismatch, %0d over capacity",
                 outcome_ok, outcome_short, outcome_mismatch, outcome_overcap);
        if (mismatches == 0 && outstanding == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/phdx_pkg.sv
rtl/phdx_parse.sv
rtl/packet_header_deframer_xor.sv
verif/deframe_checker.sv
verif/testbench.sv
